### sv/md5_pkg.sv
`timescale 1ns / 1ps

package md5_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0]  PAD_BYTE     = 8'h80;
   localparam logic [5:0]  LAST_LEN_POS = 6'd55;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_PAD    = 7'b0000010,
      ST_PRIME0 = 7'b0000100,
      ST_PRIME1 = 7'b0001000,
      ST_COMP   = 7'b0010000,
      ST_FIN    = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   // Per-round additive constant.
   function automatic logic [31:0] round_k(input logic [5:0] r);
      logic [31:0] k;
      case (r)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] round_s(input logic [5:0] r);
      logic [4:0] s;
      case ({r[5:4], r[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // Index of the message word that a round consumes.
   function automatic logic [3:0] round_g(input logic [5:0] r);
      logic [3:0] i;
      logic [3:0] g;
      i = r[3:0];
      case (r[5:4])
         2'd0:    g = i;
         2'd1:    g = 4'((i << 2) + i + 4'd1);
         2'd2:    g = 4'((i << 1) + i + 4'd5);
         2'd3:    g = 4'((i << 3) - i);
         default: g = i;
      endcase
      return g;
   endfunction

   function automatic logic [31:0] round_f(input logic [1:0] stage,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
      logic [31:0] f;
      case (stage)
         2'd0:    f = (b & c) | (~b & d);
         2'd1:    f = (b & d) | (c & ~d);
         2'd2:    f = b ^ c ^ d;
         2'd3:    f = c ^ (b | ~d);
         default: f = 32'h0;
      endcase
      return f;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] w;
      w = {x, x} << s;
      return w[63:32];
   endfunction

endpackage

### sv/md5_stream_hasher_core.sv
`timescale 1ns / 1ps

// MD5 hasher over a byte stream.
// Input channel req_*: one transfer per message byte (req_tuser = 1) or an
// empty transfer (req_tuser = 0); req_tlast ends the message, after the byte
// of the same transfer if there is one.
// Result channel rsp_*: two transfers per message, digest bytes 0-7 then
// bytes 8-15, first digest byte in the low bits; rsp_tlast marks the second.
// Throughput: one byte per cycle while a block fills. Every 64th byte starts
// a compression (priming the block memory read, 64 rounds on one round
// unit, a fold into the chaining words) during which req_tready is low.
// The end of a message takes the padding writes, one or two compressions
// and a load of the digest register; the first digest half appears in the
// cycle after the load.
// The digest waits in its own register, so the next message is taken while
// it is being drained; only a further digest stalls (in its load cycle)
// until both halves of the previous one are taken.
// Reset loads the initial chaining values and clears the byte count; no
// clearing pass of the block memory is needed.
module md5_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // has_byte
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // digest_half
   output logic        rsp_tuser,   // half_index
   output logic        rsp_tlast    // last_part
);
   import md5_pkg::*;

   state_type   state_ff, state_in;
   logic [31:0] mem [16];
   logic [31:0] rd_data_ff;
   logic        mem_we;
   logic [3:0]  mem_wa, mem_ra;
   logic [31:0] mem_wd;

   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] wa_ff, wb_ff, wc_ff, wd_ff;
   logic [31:0] wa_in, wb_in, wc_in, wd_in;
   logic [31:0] km_ff, km_in;
   logic [31:0] part_ff, part_in;
   logic [5:0]  pos_ff, pos_in;
   logic [60:0] msg_ff, msg_in;
   logic [5:0]  r_ff, r_in;
   logic [3:0]  w_ff, w_in;
   logic        pad_ff, pad_in;
   logic        len_ok_ff, len_ok_in;
   logic        first_pad_ff, first_pad_in;
   logic        last_pend_ff, last_pend_in;
   logic [127:0] dig_ff, dig_in;
   logic        out_valid_ff, out_valid_in;
   logic        half_ff, half_in;

   logic        accept;
   logic [5:0]  pos_next;
   logic [63:0] bit_len;
   logic [31:0] pad_word;
   logic [31:0] t_sum;
   logic [5:0]  k_idx;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = half_ff ? dig_ff[127:64] : dig_ff[63:0];
   assign rsp_tuser  = half_ff;
   assign rsp_tlast  = half_ff;

   assign pos_next = pos_ff + {5'd0, req_tuser};
   assign bit_len  = {msg_ff, 3'b000};
   assign t_sum    = round_f(r_ff[5:4], wb_ff, wc_ff, wd_ff) + wa_ff + km_ff;
   assign k_idx    = (state_ff == ST_PRIME1) ? 6'd0 : 6'(r_ff + 6'd1);

   // Word written during padding: kept message bytes, the 0x80 marker, zero
   // fill and the bit length in the last two words of the final block.
   always_comb begin
      pad_word = 32'h0;
      if (first_pad_ff) begin
         for (int i = 0; i < 4; i++) begin
            if (i < int'(pos_ff[1:0])) pad_word[8*i +: 8] = part_ff[8*i +: 8];
            else if (i == int'(pos_ff[1:0])) pad_word[8*i +: 8] = PAD_BYTE;
         end
      end
      if (len_ok_ff && w_ff == 4'd14) pad_word = bit_len[31:0];
      if (len_ok_ff && w_ff == 4'd15) pad_word = bit_len[63:32];
   end

   always_comb begin
      state_in     = state_ff;
      chain_in     = chain_ff;
      wa_in        = wa_ff;
      wb_in        = wb_ff;
      wc_in        = wc_ff;
      wd_in        = wd_ff;
      km_in        = km_ff;
      part_in      = part_ff;
      pos_in       = pos_ff;
      msg_in       = msg_ff;
      r_in         = r_ff;
      w_in         = w_ff;
      pad_in       = pad_ff;
      len_ok_in    = len_ok_ff;
      first_pad_in = first_pad_ff;
      last_pend_in = last_pend_ff;
      dig_in       = dig_ff;
      out_valid_in = out_valid_ff;
      half_in      = half_ff;
      mem_we       = 1'b0;
      mem_wa       = w_ff;
      mem_wd       = pad_word;
      mem_ra       = round_g(6'(r_ff + 6'd2));

      if (out_valid_ff && rsp_tready) begin
         half_in = !half_ff;
         if (half_ff) out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser) begin
                  part_in[8*pos_ff[1:0] +: 8] = req_tdata;
                  msg_in = msg_ff + 61'd1;
                  pos_in = pos_next;
                  if (pos_ff[1:0] == 2'd3) begin
                     mem_we = 1'b1;
                     mem_wa = pos_ff[5:2];
                     mem_wd = part_in;
                  end
               end
               if (req_tuser && pos_ff == 6'd63) begin
                  last_pend_in = req_tlast;
                  state_in     = ST_PRIME0;
               end else if (req_tlast) begin
                  w_in         = pos_next[5:2];
                  len_ok_in    = (pos_next <= LAST_LEN_POS);
                  first_pad_in = 1'b1;
                  pad_in       = 1'b1;
                  state_in     = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            mem_we       = 1'b1;
            first_pad_in = 1'b0;
            w_in         = 4'(w_ff + 4'd1);
            if (w_ff == 4'd15) state_in = ST_PRIME0;
         end
         ST_PRIME0: begin
            mem_ra   = round_g(6'd0);
            wa_in    = chain_ff[0];
            wb_in    = chain_ff[1];
            wc_in    = chain_ff[2];
            wd_in    = chain_ff[3];
            r_in     = 6'd0;
            state_in = ST_PRIME1;
         end
         ST_PRIME1: begin
            mem_ra   = round_g(6'd1);
            km_in    = round_k(k_idx) + rd_data_ff;
            state_in = ST_COMP;
         end
         ST_COMP: begin
            // Memory read runs two rounds ahead; km holds K plus the word.
            km_in = round_k(k_idx) + rd_data_ff;
            wa_in = wd_ff;
            wd_in = wc_ff;
            wc_in = wb_ff;
            wb_in = wb_ff + rotl32(t_sum, round_s(r_ff));
            r_in  = 6'(r_ff + 6'd1);
            if (r_ff == 6'd63) state_in = ST_FIN;
         end
         ST_FIN: begin
            chain_in[0] = chain_ff[0] + wa_ff;
            chain_in[1] = chain_ff[1] + wb_ff;
            chain_in[2] = chain_ff[2] + wc_ff;
            chain_in[3] = chain_ff[3] + wd_ff;
            if (pad_ff && len_ok_ff) begin
               state_in = ST_EMIT;
            end else if (pad_ff) begin
               len_ok_in    = 1'b1;
               first_pad_in = 1'b0;
               w_in         = 4'd0;
               state_in     = ST_PAD;
            end else if (last_pend_ff) begin
               last_pend_in = 1'b0;
               w_in         = pos_ff[5:2];
               len_ok_in    = (pos_ff <= LAST_LEN_POS);
               first_pad_in = 1'b1;
               pad_in       = 1'b1;
               state_in     = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff) begin
               dig_in       = {chain_ff[3], chain_ff[2], chain_ff[1], chain_ff[0]};
               out_valid_in = 1'b1;
               half_in      = 1'b0;
               chain_in[0]  = INIT_A;
               chain_in[1]  = INIT_B;
               chain_in[2]  = INIT_C;
               chain_in[3]  = INIT_D;
               pos_in       = 6'd0;
               msg_in       = 61'd0;
               pad_in       = 1'b0;
               len_ok_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chain_ff[0]  <= INIT_A;
         chain_ff[1]  <= INIT_B;
         chain_ff[2]  <= INIT_C;
         chain_ff[3]  <= INIT_D;
         pos_ff       <= 6'd0;
         msg_ff       <= 61'd0;
         r_ff         <= 6'd0;
         pad_ff       <= 1'b0;
         len_ok_ff    <= 1'b0;
         first_pad_ff <= 1'b0;
         last_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         pos_ff       <= pos_in;
         msg_ff       <= msg_in;
         r_ff         <= r_in;
         pad_ff       <= pad_in;
         len_ok_ff    <= len_ok_in;
         first_pad_ff <= first_pad_in;
         last_pend_ff <= last_pend_in;
         out_valid_ff <= out_valid_in;
         half_ff      <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff   <= wa_in;
      wb_ff   <= wb_in;
      wc_ff   <= wc_in;
      wd_ff   <= wd_in;
      km_ff   <= km_in;
      part_ff <= part_in;
      w_ff    <= w_in;
      dig_ff  <= dig_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP || state_ff == ST_PRIME0 || state_ff == ST_PRIME1) |-> !mem_we)
      else $error("block memory written during compression");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP && r_ff == 6'd63) |=> (state_ff == ST_FIN))
      else $error("compression did not end after the last round");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tlast))
      else $error("second digest half missing");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_tvalid) |=> (state_ff == ST_EMIT))
      else $error("digest loaded over an undelivered one");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD && w_ff == 4'd15) |=> (state_ff == ST_PRIME0))
      else $error("padding did not start a compression");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import md5_pkg::*;

   typedef struct packed {
      logic [63:0] half;
      logic        idx;
      logic        fin;
   } digest_part_type;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 900;
   localparam int MIN_MESSAGES  = 20;
   localparam int SETTLE_CYCLES = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // data_byte
   logic        req_tuser = 1'b0;    // has_byte
   logic        req_tlast = 1'b0;    // last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // digest_half
   logic        rsp_tuser;           // half_index
   logic        rsp_tlast;           // last_part

   // Sine-derived additive constants, one per round.
   logic [31:0] sine_k [0:63] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };
   int rot_amt [0:15] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
   // Message lengths around the padding and block boundaries.
   int boundary_len [0:12] = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

   logic [31:0]     chain_abcd [0:3];
   logic [31:0]     msg_block [0:15];
   logic [5:0]      fill_pos;
   logic [60:0]     byte_total;
   digest_part_type digest_parts_due [$];
   digest_part_type want;
   bit              no_gaps = 1'b0;
   int              fault_count = 0;
   int              sent_items = 0;

   md5_stream_hasher_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void load_chain_init();
      chain_abcd[0] = INIT_A;
      chain_abcd[1] = INIT_B;
      chain_abcd[2] = INIT_C;
      chain_abcd[3] = INIT_D;
   endfunction

   function automatic void md5_compress();
      logic [31:0] a, b, c, d, f, sum;
      int r, g, sh;
      a = chain_abcd[0];
      b = chain_abcd[1];
      c = chain_abcd[2];
      d = chain_abcd[3];
      for (r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         sum = f + a + sine_k[r] + msg_block[g];
         sh = rot_amt[(r / 16) * 4 + r % 4];
         a = d;
         d = c;
         c = b;
         b = b + ((sum << sh) | (sum >> (32 - sh)));
      end
      chain_abcd[0] = chain_abcd[0] + a;
      chain_abcd[1] = chain_abcd[1] + b;
      chain_abcd[2] = chain_abcd[2] + c;
      chain_abcd[3] = chain_abcd[3] + d;
   endfunction

   // A word is cleared when its first byte lands, so stale data never leaks in.
   function automatic void store_byte(input logic [5:0] pos, input logic [7:0] value);
      if (pos[1:0] == 2'd0)
         msg_block[pos[5:2]] = 32'h0;
      msg_block[pos[5:2]][pos[1:0] * 8 +: 8] = value;
   endfunction

   function automatic void predict_transfer(input logic [7:0] data, input logic has_byte,
                                            input logic last);
      logic [63:0]     bit_len;
      int              p;
      digest_part_type part;
      if (has_byte) begin
         store_byte(fill_pos, data);
         byte_total = byte_total + 61'd1;
         fill_pos = fill_pos + 6'd1;
         if (fill_pos == 6'd0)
            md5_compress();
      end
      if (last) begin
         bit_len = {byte_total, 3'b000};
         store_byte(fill_pos, PAD_BYTE);
         for (p = fill_pos + 1; p < 64; p++)
            store_byte(6'(p), 8'h00);
         // No room left for the length field: flush this block first.
         if (fill_pos > LAST_LEN_POS) begin
            md5_compress();
            for (p = 0; p < 16; p++)
               msg_block[p] = 32'h0;
         end
         msg_block[14] = bit_len[31:0];
         msg_block[15] = bit_len[63:32];
         md5_compress();
         part.half = {chain_abcd[1], chain_abcd[0]};
         part.idx = 1'b0;
         part.fin = 1'b0;
         digest_parts_due.push_back(part);
         part.half = {chain_abcd[3], chain_abcd[2]};
         part.idx = 1'b1;
         part.fin = 1'b1;
         digest_parts_due.push_back(part);
         load_chain_init();
         fill_pos = 6'd0;
         byte_total = 61'd0;
      end
   endfunction

   task automatic send_transfer(input logic [7:0] data, input logic has_byte, input logic last);
      while (!no_gaps && $urandom_range(0, 99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= has_byte;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_transfer(data, has_byte, last);
      sent_items++;
   endtask

   // Random bytes with occasional empty transfers mixed in; the message ends
   // either on its final byte or on a separate empty transfer.
   task automatic send_message(input int len);
      bit tail_on_byte;
      int i;
      tail_on_byte = $urandom_range(0, 1);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 8)
            send_transfer(8'($urandom), 1'b0, 1'b0);
         send_transfer(8'($urandom), 1'b1, tail_on_byte && (i == len - 1));
      end
      if (len == 0 || !tail_on_byte)
         send_transfer(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_for_digests();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (digest_parts_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_message();
      send_transfer(8'hff, 1'b0, 1'b1);
   endtask

   task automatic test_byte_with_last();
      send_transfer(8'h61, 1'b1, 1'b0);
      send_transfer(8'h62, 1'b1, 1'b0);
      send_transfer(8'h63, 1'b1, 1'b1);
   endtask

   task automatic test_ignored_data();
      send_transfer(8'h00, 1'b1, 1'b0);
      send_transfer(8'hff, 1'b0, 1'b0);
      send_transfer(8'hff, 1'b1, 1'b0);
      send_transfer(8'h5a, 1'b0, 1'b0);
      send_transfer(8'hff, 1'b0, 1'b1);
   endtask

   // Digests close together, so a new one may have to wait for the previous drain.
   task automatic test_back_to_back_digests();
      send_transfer(8'h00, 1'b0, 1'b1);
      send_transfer(8'h7f, 1'b1, 1'b1);
      send_transfer(8'h00, 1'b0, 1'b1);
      send_transfer(8'h80, 1'b1, 1'b1);
      wait_for_digests();
   endtask

   task automatic test_random_messages();
      int start_items;
      int msg;
      int roll;
      int len;
      start_items = sent_items;
      msg = 0;
      while (sent_items - start_items < RANDOM_ITEMS || msg < MIN_MESSAGES) begin
         no_gaps = (msg >= 6 && msg < 11);
         roll = $urandom_range(0, 99);
         if (roll < 35)
            len = boundary_len[$urandom_range(0, 12)];
         else if (roll < 38)
            len = $urandom_range(129, 200);
         else
            len = $urandom_range(0, 40);
         send_message(len);
         if ($urandom_range(0, 9) == 0)
            wait_for_digests();
         msg++;
      end
      no_gaps = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(0, 99) >= 23);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_parts_due.size() == 0) begin
            if (fault_count < 10)
               $display("unexpected digest transfer: tdata=%h tuser=%b tlast=%b",
                        rsp_tdata, rsp_tuser, rsp_tlast);
            fault_count++;
         end else begin
            want = digest_parts_due.pop_front();
            if (rsp_tdata !== want.half || rsp_tuser !== want.idx || rsp_tlast !== want.fin) begin
               if (fault_count < 10)
                  $display("digest mismatch: expected %h/%b/%b, got %h/%b/%b",
                           want.half, want.idx, want.fin, rsp_tdata, rsp_tuser, rsp_tlast);
               fault_count++;
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      load_chain_init();
      fill_pos = 6'd0;
      byte_total = 61'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_message();
      test_byte_with_last();
      test_ignored_data();
      test_back_to_back_digests();
      test_random_messages();
      wait_for_digests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && digest_parts_due.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
